// ===== hdl/cmf_pkg.sv =====
`default_nettype none

package cmf_pkg;

    // field widths
    localparam int NUC_W    = 2;
    localparam int MMER_MAX = 15;
    localparam int WIN_W    = NUC_W * MMER_MAX;
    localparam int IDX_W    = 5;
    localparam int KLEN_W   = 5;
    localparam int MLEN_W   = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int HASH_W   = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MMER_LENGTH = 1'b1;

    // complement of every nucleotide flips its high bit
    localparam logic [WIN_W-1:0] COMP_MASK = 30'h2AAA_AAAA;
    localparam logic [WIN_W-1:0] FULL_MASK = 30'h3FFF_FFFF;

    // shift amounts of the mixing hash
    localparam int SH_A  = 21;
    localparam int SH_B  = 24;
    localparam int SH_C1 = 3;
    localparam int SH_C2 = 8;
    localparam int SH_D  = 14;
    localparam int SH_E1 = 2;
    localparam int SH_E2 = 4;
    localparam int SH_F  = 28;
    localparam int SH_G  = 31;

    // window bookkeeping that travels with the data
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             first;
        logic             last;
    } tag_t;

    // one canonized window
    typedef struct packed {
        logic [WIN_W-1:0] fwd;
        logic [WIN_W-1:0] canon;
        tag_t             tag;
    } win_t;

    // one result item
    typedef struct packed {
        logic [WIN_W-1:0] minimizer;
        logic [IDX_W-1:0] position;
        logic             is_reversed;
        logic             has_repeat;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/canonical_minimizer_finder.sv =====
// canonical k-mer minimizer finder
//
// input channel s_valid/s_ready carries one packed k-mer per item; the result
// channel m_valid/m_ready gives the canonical minimizer, its window position,
// the reverse flag and the repeat flag, one result item per input item.
// configuration: cfg_we writes cfg_data into the register picked by cfg_index
// (kmer_length, mmer_length); write only while no item is in flight.
// one canonize stage and a four-stage hash pipe are shared by all windows of
// an item: the sequencer feeds one window per cycle, n = k-m+1 windows
// (one when k<m). each window passes the canonize register, the hash stages
// and the select register; a new item is taken once the result is loaded.
// s_ready is high only while the sequencer is idle. the result register sits
// between the sides, so a new item is taken while a result waits; if the
// receiver still stalls when the next result is done, the sequencer holds it
// until the result register frees up.
// reset (aresetn low, synchronous) empties the pipe and the result register
// and sets kmer_length to 31 and mmer_length to 11.
`default_nettype none

module canonical_minimizer_finder #(
    parameter int MAX_K = 31
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [cmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cmf_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [2*MAX_K-1:0]          s_kmer_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [cmf_pkg::WIN_W-1:0]        m_minimizer,
    output logic [cmf_pkg::IDX_W-1:0]        m_position,
    output logic                             m_is_reversed,
    output logic                             m_has_repeat
);

    localparam int SR_W = 2 * MAX_K + cmf_pkg::WIN_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_PEND = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [SR_W-1:0]              sr_reg;
    logic [cmf_pkg::IDX_W-1:0]    idx_reg;
    logic [cmf_pkg::IDX_W-1:0]    last_reg;
    logic [cmf_pkg::KLEN_W-1:0]   kmer_length_reg;
    logic [cmf_pkg::MLEN_W-1:0]   mmer_length_reg;
    cmf_pkg::res_t                res_reg;
    logic                         m_valid_reg;
    logic [cmf_pkg::IDX_W-1:0]    last_next;
    logic                         s_accept;
    logic                         out_free;
    logic                         load_out;
    logic                         issue_valid;
    cmf_pkg::tag_t                issue_tag;
    logic                         can_valid;
    cmf_pkg::win_t                can_win;
    logic                         hash_valid;
    cmf_pkg::win_t                hash_win;
    logic [cmf_pkg::HASH_W-1:0]   hash_val;
    logic                         sel_done;
    cmf_pkg::res_t                sel_result;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_PEND) && out_free;

    // index of the last window
    assign last_next = (kmer_length_reg >= {1'b0, mmer_length_reg}) ?
                       (kmer_length_reg - {1'b0, mmer_length_reg}) : '0;

    // window issue
    assign issue_valid     = (state_reg == ST_SCAN);
    assign issue_tag.idx   = idx_reg;
    assign issue_tag.first = (idx_reg == '0);
    assign issue_tag.last  = (idx_reg == last_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_SCAN;
            ST_SCAN: if (idx_reg == last_reg) state_next = ST_WAIT;
            ST_WAIT: if (sel_done) state_next = ST_PEND;
            ST_PEND: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            kmer_length_reg <= 5'd31;
            mmer_length_reg <= 4'd11;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    cmf_pkg::CFG_KMER_LENGTH: kmer_length_reg <= cfg_data;
                    cmf_pkg::CFG_MMER_LENGTH:
                        mmer_length_reg <= cfg_data[cmf_pkg::MLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // k-mer shift line and window counter
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sr_reg   <= {{cmf_pkg::WIN_W{1'b0}}, s_kmer_value};
            idx_reg  <= '0;
            last_reg <= last_next;
        end else if (issue_valid) begin
            sr_reg  <= {2'b00, sr_reg[SR_W-1:2]};
            idx_reg <= idx_reg + 1'b1;
        end
        if (load_out) begin
            res_reg <= sel_result;
        end
    end

    cmf_canon u_canon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (issue_valid),
        .in_raw      (sr_reg[cmf_pkg::WIN_W-1:0]),
        .in_tag      (issue_tag),
        .mmer_length (mmer_length_reg),
        .out_valid   (can_valid),
        .out_win     (can_win)
    );

    cmf_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (can_valid),
        .in_win    (can_win),
        .out_valid (hash_valid),
        .out_win   (hash_win),
        .out_hash  (hash_val)
    );

    cmf_select u_select (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (hash_valid),
        .in_win   (hash_win),
        .in_hash  (hash_val),
        .done     (sel_done),
        .result   (sel_result)
    );

    assign m_valid       = m_valid_reg;
    assign m_minimizer   = res_reg.minimizer;
    assign m_position    = res_reg.position;
    assign m_is_reversed = res_reg.is_reversed;
    assign m_has_repeat  = res_reg.has_repeat;

    // the last window leaves the pipe only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_done |-> (state_reg == ST_WAIT))
        else $error("window scan finished outside of wait state");

    // the window counter never runs past the last window
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg <= last_reg))
        else $error("window index beyond last window");

    // a pending result reaches the output once the register is free
    a_pend_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("pending result not delivered");

    // no window enters the pipe while idle
    a_no_issue_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> !can_valid)
        else $error("window issued while idle");

endmodule

`default_nettype wire

// ===== hdl/cmf_canon.sv =====
`default_nettype none

module cmf_canon (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire logic [cmf_pkg::WIN_W-1:0]   in_raw,
    input  wire cmf_pkg::tag_t               in_tag,
    input  wire logic [cmf_pkg::MLEN_W-1:0]  mmer_length,
    output logic                             out_valid,
    output cmf_pkg::win_t                    out_win
);

    logic                      valid_reg;
    cmf_pkg::win_t             win_reg;
    logic [cmf_pkg::WIN_W-1:0] mask;
    logic [cmf_pkg::WIN_W-1:0] fwd;
    logic [cmf_pkg::WIN_W-1:0] rev_all;
    logic [cmf_pkg::WIN_W-1:0] rc;
    logic [5:0]                drop;

    // keep the low m nucleotides of the window
    assign drop = 6'd30 - {1'b0, mmer_length, 1'b0};
    assign mask = cmf_pkg::FULL_MASK >> drop;
    assign fwd  = in_raw & mask;

    // reverse all fifteen nucleotide slots, then drop the unused ones
    always_comb begin
        for (int j = 0; j < cmf_pkg::MMER_MAX; j++) begin
            rev_all[cmf_pkg::NUC_W*(cmf_pkg::MMER_MAX-1-j) +: cmf_pkg::NUC_W] =
                fwd[cmf_pkg::NUC_W*j +: cmf_pkg::NUC_W];
        end
    end

    assign rc = (rev_all ^ cmf_pkg::COMP_MASK) >> drop;

    // register the canonical form with its forward value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        win_reg.fwd   <= fwd;
        win_reg.canon <= (rc < fwd) ? rc : fwd;
        win_reg.tag   <= in_tag;
    end

    assign out_valid = valid_reg;
    assign out_win   = win_reg;

endmodule

`default_nettype wire

// ===== hdl/cmf_hash.sv =====
`default_nettype none

module cmf_hash (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire cmf_pkg::win_t               in_win,
    output logic                             out_valid,
    output cmf_pkg::win_t                    out_win,
    output logic [cmf_pkg::HASH_W-1:0]       out_hash
);

    logic [3:0]                 v_reg;
    cmf_pkg::win_t              w1_reg, w2_reg, w3_reg, w4_reg;
    logic [cmf_pkg::HASH_W-1:0] h1_reg, h2_reg, h3_reg, h4_reg;
    logic [cmf_pkg::HASH_W-1:0] x0, a, b, c;
    logic [cmf_pkg::HASH_W-1:0] h1_next, h2_next, h3_next, h4_next;

    // one shift-add per stage and one xor-shift in each stage but the last
    always_comb begin
        x0      = {{(cmf_pkg::HASH_W-cmf_pkg::WIN_W){1'b0}}, in_win.canon};
        a       = (~x0) + (x0 << cmf_pkg::SH_A);
        h1_next = a ^ (a >> cmf_pkg::SH_B);
        b       = h1_reg + (h1_reg << cmf_pkg::SH_C1) + (h1_reg << cmf_pkg::SH_C2);
        h2_next = b ^ (b >> cmf_pkg::SH_D);
        c       = h2_reg + (h2_reg << cmf_pkg::SH_E1) + (h2_reg << cmf_pkg::SH_E2);
        h3_next = c ^ (c >> cmf_pkg::SH_F);
        h4_next = h3_reg + (h3_reg << cmf_pkg::SH_G);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[2:0], in_valid};
        end
        h1_reg <= h1_next;
        h2_reg <= h2_next;
        h3_reg <= h3_next;
        h4_reg <= h4_next;
        w1_reg <= in_win;
        w2_reg <= w1_reg;
        w3_reg <= w2_reg;
        w4_reg <= w3_reg;
    end

    assign out_valid = v_reg[3];
    assign out_win   = w4_reg;
    assign out_hash  = h4_reg;

endmodule

`default_nettype wire

// ===== hdl/cmf_select.sv =====
`default_nettype none

module cmf_select (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire cmf_pkg::win_t               in_win,
    input  wire logic [cmf_pkg::HASH_W-1:0]  in_hash,
    output logic                             done,
    output cmf_pkg::res_t                    result
);

    logic                       done_reg;
    cmf_pkg::res_t              best_reg;
    logic [cmf_pkg::HASH_W-1:0] best_hash_reg;
    logic                       take_new;
    logic                       tie;

    assign take_new = in_win.tag.first || (in_hash < best_hash_reg);
    assign tie      = (in_hash == best_hash_reg);

    // keep the least hash, latest window among ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= in_valid && in_win.tag.last;
        end
        if (in_valid) begin
            if (take_new) begin
                best_reg.minimizer   <= in_win.canon;
                best_hash_reg        <= in_hash;
                best_reg.position    <= in_win.tag.idx;
                best_reg.is_reversed <= (in_win.canon != in_win.fwd);
                best_reg.has_repeat  <= 1'b0;
            end else if (tie) begin
                best_reg.position    <= in_win.tag.idx;
                best_reg.is_reversed <= (best_reg.minimizer != in_win.fwd);
                best_reg.has_repeat  <= 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = best_reg;

endmodule

`default_nettype wire
